/* rtl/itoa_pkg.sv */
// Shared types, codes and the digit-to-ASCII helper for the integer formatter.
`timescale 1ns / 1ps
`default_nettype none
package itoa_pkg;

  typedef enum logic [1:0] {
    CMD_HEX_LOWER = 2'd0,
    CMD_HEX_UPPER = 2'd1,
    CMD_DECIMAL   = 2'd2,
    CMD_POINTER   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_PFX0,
    S_PFX1,
    S_SKIP,
    S_EMIT
  } state_t;

  // Handshake between the sequencer and the binary-to-BCD converter.
  typedef struct packed {
    logic busy;
    logic done;
  } conv_status_t;

  localparam int BinWidth  = 32;
  localparam int BcdDigits = 10;
  localparam int BcdWidth  = 4 * BcdDigits;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChX     = 8'h78;
  localparam logic [7:0] ChLower = 8'h61;
  localparam logic [7:0] ChUpper = 8'h41;

  // One hex or decimal digit to its ASCII code.
  function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [7:0] base;
    base = upper ? ChUpper : ChLower;
    if (nib < 4'd10) begin
      return ChZero + {4'd0, nib};
    end
    return base + {4'd0, nib} - 8'd10;
  endfunction

endpackage
`default_nettype wire

/* rtl/itoa_if.sv */
// Stream interfaces for the formatter's input items and output characters.
`timescale 1ns / 1ps
`default_nettype none
interface itoa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] value;
  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

interface itoa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;
  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface
`default_nettype wire

/* rtl/itoa_bcd_conv.sv */
// Iterative shift-and-add-3 binary to BCD converter, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module itoa_bcd_conv
  import itoa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [BinWidth-1:0]   bin_in,
  output conv_status_t               status,
  output logic [BcdWidth-1:0]        bcd
);

  localparam int CntWidth = $clog2(BinWidth + 1);

  logic [BinWidth-1:0] bin;
  logic [CntWidth-1:0] cnt;
  logic                done;
  logic [BcdWidth-1:0] adj;

  // Digits of five or more get three added before the shift.
  always_comb begin
    for (int d = 0; d < BcdDigits; d++) begin
      adj[4*d +: 4] = (bcd[4*d +: 4] >= 4'd5) ? bcd[4*d +: 4] + 4'd3 : bcd[4*d +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CntWidth'(1));
      if (start) begin
        cnt <= CntWidth'(BinWidth);
      end else if (cnt != '0) begin
        cnt <= cnt - CntWidth'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= bin_in;
      bcd <= '0;
    end else if (cnt != '0) begin
      bcd <= {adj[BcdWidth-2:0], bin[BinWidth-1]};
      bin <= {bin[BinWidth-2:0], 1'b0};
    end
  end

  assign status.busy = (cnt != '0);
  assign status.done = done;

endmodule
`default_nettype wire

/* rtl/integer_to_ascii_formatter_top.sv */
// Top level of the unsigned integer to ASCII hex/decimal formatter.
//
// Usage: an input item (command, value) is offered on din; each transfer on
// dout carries one ASCII character, most significant digit first, with last
// set on the final character of the item. Leading zeros are dropped; a zero
// value yields a single '0'. Pointer form prefixes "0x" and prints all 64
// bits in lower-case hex; the other forms use the low 32 bits only.
//
// Flow: one item at a time; din.ready stays low from the transfer until the
// last character has been handed to the output register. Hex items skip
// leading zeros, then emit one character per digit left. Pointer items first
// emit the two prefix characters. Decimal items first wait for the BCD
// converter (32 shift-and-add-3 steps and its done flag), then skip and emit
// over 10 digit positions.
//
// The output register lets the next item be accepted while the last
// character still waits. When the receiver stalls, the sequencer simply
// holds at its next character and the pending character stays stable on dout.
// Reset (synchronous, active high) returns to idle and empties the output.
`timescale 1ns / 1ps
`default_nettype none
module integer_to_ascii_formatter_top
  import itoa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  itoa_in_if.sink    din,
  itoa_out_if.source dout
);

  localparam int RemWidth = 5;

  state_t              state, state_next;
  logic [63:0]         nib, nib_next;
  logic [RemWidth-1:0] remaining, remaining_next;
  logic                upper, upper_next;

  logic                ov, ov_next;
  logic [7:0]          ochar, ochar_next;
  logic                olast, olast_next;

  logic                conv_start;
  conv_status_t        conv_st;
  logic [BcdWidth-1:0] conv_bcd;

  logic                can_push;
  logic                in_xfer;

  itoa_bcd_conv u_conv (
    .clk    (clk),
    .rst    (rst),
    .start  (conv_start),
    .bin_in (din.value[BinWidth-1:0]),
    .status (conv_st),
    .bcd    (conv_bcd)
  );

  assign din.ready      = (state == S_IDLE);
  assign in_xfer        = din.valid && din.ready;
  assign can_push       = !ov || dout.ready;
  assign dout.valid     = ov;
  assign dout.character = ochar;
  assign dout.last      = olast;

  always_comb begin
    state_next     = state;
    nib_next       = nib;
    remaining_next = remaining;
    upper_next     = upper;
    conv_start     = 1'b0;
    ov_next        = ov && !dout.ready;
    ochar_next     = ochar;
    olast_next     = olast;

    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          upper_next = 1'b0;
          unique case (cmd_t'(din.command))
            CMD_HEX_LOWER, CMD_HEX_UPPER: begin
              upper_next     = (cmd_t'(din.command) == CMD_HEX_UPPER);
              nib_next       = {din.value[31:0], 32'd0};
              remaining_next = RemWidth'(8);
              state_next     = S_SKIP;
            end
            CMD_DECIMAL: begin
              conv_start = 1'b1;
              state_next = S_CONV;
            end
            CMD_POINTER: begin
              nib_next       = din.value;
              remaining_next = RemWidth'(16);
              state_next     = S_PFX0;
            end
          endcase
        end
      end
      S_CONV: begin
        if (conv_st.done) begin
          nib_next       = {conv_bcd, 24'd0};
          remaining_next = RemWidth'(BcdDigits);
          state_next     = S_SKIP;
        end
      end
      S_PFX0: begin
        if (can_push) begin
          ov_next    = 1'b1;
          ochar_next = ChZero;
          olast_next = 1'b0;
          state_next = S_PFX1;
        end
      end
      S_PFX1: begin
        if (can_push) begin
          ov_next    = 1'b1;
          ochar_next = ChX;
          olast_next = 1'b0;
          state_next = S_SKIP;
        end
      end
      S_SKIP: begin
        // Drop one leading zero per cycle, always keeping the final digit.
        if (nib[63:60] == 4'd0 && remaining != RemWidth'(1)) begin
          nib_next       = {nib[59:0], 4'd0};
          remaining_next = remaining - RemWidth'(1);
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (can_push) begin
          ov_next        = 1'b1;
          ochar_next     = digit_char(nib[63:60], upper);
          olast_next     = (remaining == RemWidth'(1));
          nib_next       = {nib[59:0], 4'd0};
          remaining_next = remaining - RemWidth'(1);
          if (remaining == RemWidth'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      ov    <= ov_next;
    end
  end

  always_ff @(posedge clk) begin
    nib       <= nib_next;
    remaining <= remaining_next;
    upper     <= upper_next;
    ochar     <= ochar_next;
    olast     <= olast_next;
  end

  // The converter finishes only while the sequencer is waiting for it.
  a_done_in_conv: assert property (@(posedge clk) disable iff (rst)
    conv_st.done |-> state == S_CONV)
    else $error("BCD converter finished outside the conversion wait");

  // A new item is never taken while a conversion is still running.
  a_ready_not_busy: assert property (@(posedge clk) disable iff (rst)
    din.ready |-> !conv_st.busy)
    else $error("input ready while converter busy");

  // Emission never runs out of digits before the last one is flagged.
  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> remaining != '0)
    else $error("emit state with no digits left");

  // The flagged last character returns the sequencer to idle.
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && can_push && remaining == RemWidth'(1) |=> state == S_IDLE && olast)
    else $error("last character did not end the item");

endmodule
`default_nettype wire
